// ===== hdl/ohm_pkg.sv =====
// Shared types, constants and codes for the open-addressing hash map unit.
`default_nettype none
package ohm_pkg;

    // Table geometry: the slot count is a power of two so that the probe index wraps freely.
    localparam int SLOT_W      = 5;
    localparam int SLOTS       = 2 ** SLOT_W;
    localparam int CNT_W       = SLOT_W + 1;
    // A new key may not take a free slot once this many slots are in use.
    localparam int USED_CAP    = (2 * SLOTS) / 3;
    localparam int PERTURB_SHIFT = 5;

    // Field widths fixed by the interface.
    localparam int WORD_W      = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_IDX_W   = 5;
    localparam int OUT_CNT_W   = 5;
    localparam int MARK_W      = 2;

    // Request modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_GET = 2'd0,
        MODE_SET = 2'd1,
        MODE_DEL = 2'd2
    } t_mode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    // Slot marks.
    typedef enum logic [MARK_W-1:0] {
        MARK_FREE = 2'd0,
        MARK_LIVE = 2'd1,
        MARK_GONE = 2'd2
    } t_mark;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_COMMIT
    } t_state;

    // Input transfer payload.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] key_hash;
        logic [WORD_W-1:0] value;
    } t_req;

    // Output transfer payload.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [WORD_W-1:0]    value_out;
        logic [OUT_IDX_W-1:0] slot_index;
        logic [OUT_CNT_W-1:0] live_count;
    } t_rsp;

    // One slot of the table memory.
    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] item;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

// ===== hdl/ohm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ohm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/open_addressing_hash_map_unit.sv =====
// Top level of the open-addressing hash map: probe sequencer around one slot memory.
//
//   Channel | Direction | Handshake             | Payload
//   in      | input     | i_in_valid / o_in_stall | ohm_pkg::t_req (mode, key, key_hash, value)
//   out     | output    | o_out_valid / i_out_stall | ohm_pkg::t_rsp (status, value_out, ...)
//
// A request passes through a fetch step, one evaluation per slot probed (1 to 2 * SLOTS) and a commit step.
// The single read port of the slot memory and its registered read set one probe per cycle.
// After reset a clearing pass marks every slot free; no input meanwhile.
// The result sits in an output register, so the next request is taken while it waits.
// A request whose result register is still full holds in its commit step until it drains.
`default_nettype none
module open_addressing_hash_map_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ohm_pkg::t_req i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ohm_pkg::t_rsp      o_out
);

    // Sequencer and counters.
    ohm_pkg::t_state                r_state, n_state;
    logic [ohm_pkg::SLOT_W-1:0]     r_clr, n_clr;
    logic [ohm_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [ohm_pkg::CNT_W-1:0]      r_live, n_live;
    logic [ohm_pkg::CNT_W-1:0]      r_used, n_used;
    logic                           r_out_valid, n_out_valid;

    // Request and probe payload.
    ohm_pkg::t_req                  r_req, n_req;
    logic [ohm_pkg::SLOT_W-1:0]     r_idx, n_idx;
    logic [ohm_pkg::WORD_W-1:0]     r_perturb, n_perturb;
    logic                           r_gone_seen, n_gone_seen;
    logic [ohm_pkg::SLOT_W-1:0]     r_gone_idx, n_gone_idx;
    logic                           r_found, n_found;
    logic                           r_have_cand, n_have_cand;
    logic                           r_cand_free, n_cand_free;
    logic [ohm_pkg::SLOT_W-1:0]     r_hit_idx, n_hit_idx;
    logic [ohm_pkg::WORD_W-1:0]     r_item, n_item;
    ohm_pkg::t_rsp                  r_out, n_out;

    // Memory port signals.
    logic                           w_we;
    logic [ohm_pkg::SLOT_W-1:0]     w_waddr;
    ohm_pkg::t_entry                w_wentry;
    logic [ohm_pkg::SLOT_W-1:0]     w_raddr;
    logic [ohm_pkg::ENTRY_W-1:0]    w_rdata;
    ohm_pkg::t_entry                w_rentry;

    // Probe step unit and decode of the slot just read.
    logic [ohm_pkg::SLOT_W-1:0]     w_next_idx;
    logic                           w_is_free;
    logic                           w_is_hit;
    logic                           w_is_gone;
    logic                           w_last;
    logic                           w_in_xfer;
    logic                           w_out_free;
    logic                           w_cap_hit;
    logic [ohm_pkg::WORD_W-1:0]     w_live_wide;
    logic [ohm_pkg::WORD_W-1:0]     w_slot_wide;

    // Slot memory: mark, key and item of every slot in one word.
    ohm_ram #(
        .WIDTH (ohm_pkg::ENTRY_W),
        .DEPTH (ohm_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rentry = ohm_pkg::t_entry'(w_rdata);

    // Shared step unit: i = 5i + perturb + 1, wrapping at the slot count.
    assign w_next_idx = (r_idx << 2) + r_idx + r_perturb[ohm_pkg::SLOT_W-1:0]
                        + ohm_pkg::SLOT_W'(1);

    // Classify the slot whose data has just come out of the memory.
    assign w_is_free = (w_rentry.mark == ohm_pkg::MARK_FREE);
    assign w_is_hit  = (w_rentry.mark == ohm_pkg::MARK_LIVE) && (w_rentry.key == r_req.key);
    assign w_is_gone = !w_is_free && (w_rentry.mark != ohm_pkg::MARK_LIVE);
    assign w_last    = (r_cnt == '1);

    // While probing, the next slot is read during the evaluation of the current one.
    assign w_raddr = (r_state == ohm_pkg::S_EVAL) ? w_next_idx : r_idx;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cap_hit  = (r_used >= ohm_pkg::CNT_W'(ohm_pkg::USED_CAP));

    // Handshake outputs.
    assign o_in_stall  = (r_state != ohm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next state, probe bookkeeping and commit of the result.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_live      = r_live;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_idx       = r_idx;
        n_perturb   = r_perturb;
        n_gone_seen = r_gone_seen;
        n_gone_idx  = r_gone_idx;
        n_found     = r_found;
        n_have_cand = r_have_cand;
        n_cand_free = r_cand_free;
        n_hit_idx   = r_hit_idx;
        n_item      = r_item;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_hit_idx;
        w_wentry    = '{mark: ohm_pkg::MARK_LIVE, key: r_req.key, item: r_req.value};
        w_live_wide = '0;
        w_slot_wide = '0;

        // A waiting result leaves once the far side takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ohm_pkg::S_CLEAR: begin
                w_we     = 1'b1;
                w_waddr  = r_clr;
                w_wentry = '{mark: ohm_pkg::MARK_FREE, key: '0, item: '0};
                n_clr    = r_clr + ohm_pkg::SLOT_W'(1);
                if (r_clr == '1) begin
                    n_state = ohm_pkg::S_IDLE;
                end
            end

            ohm_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_req       = i_in;
                    n_idx       = i_in.key_hash[ohm_pkg::SLOT_W-1:0];
                    n_perturb   = i_in.key_hash;
                    n_cnt       = '0;
                    n_gone_seen = 1'b0;
                    n_gone_idx  = '0;
                    n_state     = ohm_pkg::S_FETCH;
                end
            end

            ohm_pkg::S_FETCH: begin
                n_state = ohm_pkg::S_EVAL;
            end

            ohm_pkg::S_EVAL: begin
                n_found     = 1'b0;
                n_have_cand = 1'b0;
                n_cand_free = 1'b0;
                n_hit_idx   = '0;
                n_item      = w_rentry.item;
                if (w_is_gone && !r_gone_seen) begin
                    n_gone_seen = 1'b1;
                    n_gone_idx  = r_idx;
                end
                priority if (w_is_free) begin
                    // A free slot ends the probe; an earlier deleted slot is preferred.
                    n_have_cand = 1'b1;
                    n_cand_free = !r_gone_seen;
                    n_hit_idx   = r_gone_seen ? r_gone_idx : r_idx;
                    n_state     = ohm_pkg::S_COMMIT;
                end else if (w_is_hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_idx;
                    n_state   = ohm_pkg::S_COMMIT;
                end else if (w_last) begin
                    // Probe bound reached: only a deleted slot passed on the way can serve.
                    n_have_cand = n_gone_seen;
                    n_hit_idx   = n_gone_idx;
                    n_state     = ohm_pkg::S_COMMIT;
                end else begin
                    n_idx     = w_next_idx;
                    n_perturb = r_perturb >> ohm_pkg::PERTURB_SHIFT;
                    n_cnt     = r_cnt + ohm_pkg::CNT_W'(1);
                end
            end

            ohm_pkg::S_COMMIT: begin
                if (w_out_free) begin
                    n_out.status     = ohm_pkg::STAT_MISS;
                    n_out.value_out  = '0;
                    n_out.slot_index = '0;
                    w_slot_wide      = ohm_pkg::WORD_W'(r_hit_idx);
                    priority if (r_req.mode == ohm_pkg::MODE_SET) begin
                        if (r_found) begin
                            w_we             = 1'b1;
                            n_out.status     = ohm_pkg::STAT_OK;
                            n_out.slot_index = w_slot_wide[ohm_pkg::OUT_IDX_W-1:0];
                        end else if (!r_have_cand || (r_cand_free && w_cap_hit)) begin
                            n_out.status = ohm_pkg::STAT_FULL;
                        end else begin
                            w_we             = 1'b1;
                            n_live           = r_live + ohm_pkg::CNT_W'(1);
                            if (r_cand_free) begin
                                n_used = r_used + ohm_pkg::CNT_W'(1);
                            end
                            n_out.status     = ohm_pkg::STAT_OK;
                            n_out.slot_index = w_slot_wide[ohm_pkg::OUT_IDX_W-1:0];
                        end
                    end else if (r_req.mode == ohm_pkg::MODE_DEL) begin
                        if (r_found) begin
                            w_we     = 1'b1;
                            w_wentry = '{mark: ohm_pkg::MARK_GONE, key: r_req.key,
                                         item: r_item};
                            if (r_live != '0) begin
                                n_live = r_live - ohm_pkg::CNT_W'(1);
                            end
                            n_out.status     = ohm_pkg::STAT_OK;
                            n_out.slot_index = w_slot_wide[ohm_pkg::OUT_IDX_W-1:0];
                        end
                    end else begin
                        // Get, and the unused mode code, which behaves as a get.
                        if (r_found) begin
                            n_out.status     = ohm_pkg::STAT_OK;
                            n_out.value_out  = r_item;
                            n_out.slot_index = w_slot_wide[ohm_pkg::OUT_IDX_W-1:0];
                        end
                    end
                    w_live_wide      = ohm_pkg::WORD_W'(n_live);
                    n_out.live_count = w_live_wide[ohm_pkg::OUT_CNT_W-1:0];
                    n_out_valid      = 1'b1;
                    n_state          = ohm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ohm_pkg::S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ohm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_live      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            r_live      <= n_live;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_perturb   <= n_perturb;
        r_gone_seen <= n_gone_seen;
        r_gone_idx  <= n_gone_idx;
        r_found     <= n_found;
        r_have_cand <= n_have_cand;
        r_cand_free <= n_cand_free;
        r_hit_idx   <= n_hit_idx;
        r_item      <= n_item;
        r_out       <= n_out;
    end

`ifndef NO_ASSERTIONS
    // Live keys are a subset of the slots in use.
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used)
        else $error("live key count exceeds used slot count");

    // The load cap keeps the used-slot count at or below its limit.
    a_used_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ohm_pkg::CNT_W'(ohm_pkg::USED_CAP))
        else $error("used slot count passed the load cap");

    // The memory is written only by the clearing pass or a commit.
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ohm_pkg::S_CLEAR || r_state == ohm_pkg::S_COMMIT))
        else $error("slot memory written outside clear or commit");

    // The probe bound ends the search.
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ohm_pkg::S_EVAL && w_last) |=> r_state == ohm_pkg::S_COMMIT)
        else $error("probe ran past its bound");

    // An accepted request starts its first memory read next.
    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == ohm_pkg::S_FETCH)
        else $error("accepted request did not start a probe");
`endif

endmodule
`default_nettype wire

// ===== bench/open_addressing_hash_map_unit_tb.sv =====
// Self-checking testbench for the open-addressing hash map unit with its own table predictor.
`timescale 1ns / 1ps
module open_addressing_hash_map_unit_tb;
    import ohm_pkg::*;

    // Odd mode code, which the block treats as a lookup.
    localparam logic [MODE_W-1:0] MODE_ODD = 2'd3;
    localparam int PROBE_LIMIT = 2 * SLOTS;
    localparam int POOL_KEYS = 40;
    // Watchdog limit, set with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    // Drain allowance: the longest request, with one probe per step of the bound, plus slack.
    localparam int DRAIN_CYCLES = 3 + PROBE_LIMIT + 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp out_rsp;

    // Predicted table contents and counters.
    t_mark       tbl_mark [SLOTS];
    logic [31:0] tbl_key  [SLOTS];
    logic [31:0] tbl_item [SLOTS];
    int          tbl_live;
    int          tbl_used;

    // Results predicted at each accepted request, oldest first.
    t_rsp expected_rsp[$];
    t_rsp head_rsp;
    int   fail_count = 0;
    int   cycle_count = 0;

    // Idling control shared by both sides of the block.
    bit   bursts_on = 1'b1;
    int   send_quiet = 0;
    int   stall_left = 0;
    int   run_left = 0;

    // Keys with fixed hashes, so that lookups and deletes find earlier sets.
    logic [31:0] pool_key  [POOL_KEYS];
    logic [31:0] pool_hash [POOL_KEYS];

    open_addressing_hash_map_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out_rsp)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Probe the predicted table for one request, apply it and return the expected result.
    function automatic t_rsp map_predict(input t_req r);
        t_rsp        rsp;
        logic [4:0]  idx;
        logic [4:0]  pos;
        logic [4:0]  gone_idx;
        logic [31:0] perturb;
        logic [63:0] nxt;
        bit          gone_seen;
        bit          found;
        bit          have_cand;
        bit          cand_free;
        bit          done;
        int          n;
        begin
            idx = r.key_hash[4:0];
            perturb = r.key_hash;
            pos = '0;
            gone_idx = '0;
            gone_seen = 1'b0;
            found = 1'b0;
            have_cand = 1'b0;
            cand_free = 1'b0;
            done = 1'b0;
            for (n = 0; n < PROBE_LIMIT && !done; n++) begin
                case (tbl_mark[idx])
                    MARK_FREE: begin
                        have_cand = 1'b1;
                        if (gone_seen) begin
                            pos = gone_idx;
                        end else begin
                            pos = idx;
                            cand_free = 1'b1;
                        end
                        done = 1'b1;
                    end
                    MARK_LIVE: begin
                        if (tbl_key[idx] == r.key) begin
                            found = 1'b1;
                            pos = idx;
                            done = 1'b1;
                        end
                    end
                    default: begin
                        if (!gone_seen) begin
                            gone_seen = 1'b1;
                            gone_idx = idx;
                        end
                    end
                endcase
                if (!done) begin
                    nxt = 64'd5 * idx + perturb + 64'd1;
                    idx = nxt[4:0];
                    perturb = perturb >> PERTURB_SHIFT;
                end
            end
            // The probe ran out of steps: only a deleted slot can take a new key.
            if (!done && gone_seen) begin
                have_cand = 1'b1;
                pos = gone_idx;
            end

            rsp = '0;
            rsp.status = STAT_MISS;
            if (r.mode == MODE_SET) begin
                if (found) begin
                    tbl_item[pos] = r.value;
                    rsp.status = STAT_OK;
                    rsp.slot_index = pos;
                end else if (!have_cand || (cand_free && (tbl_used + 1) * 3 > SLOTS * 2)) begin
                    rsp.status = STAT_FULL;
                end else begin
                    if (cand_free) begin
                        tbl_used++;
                    end
                    tbl_mark[pos] = MARK_LIVE;
                    tbl_key[pos] = r.key;
                    tbl_item[pos] = r.value;
                    tbl_live++;
                    rsp.status = STAT_OK;
                    rsp.slot_index = pos;
                end
            end else if (r.mode == MODE_DEL) begin
                if (found) begin
                    tbl_mark[pos] = MARK_GONE;
                    if (tbl_live > 0) begin
                        tbl_live--;
                    end
                    rsp.status = STAT_OK;
                    rsp.slot_index = pos;
                end
            end else begin
                // Lookup, which the odd mode code also performs.
                if (found) begin
                    rsp.status = STAT_OK;
                    rsp.value_out = tbl_item[pos];
                    rsp.slot_index = pos;
                end
            end
            rsp.live_count = tbl_live[OUT_CNT_W-1:0];
            return rsp;
        end
    endfunction

    // Present one request from a falling edge and hold it until its transfer.
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [31:0] key,
                            input logic [31:0] key_hash, input logic [31:0] value);
        t_req r;
        begin
            r.mode = mode;
            r.key = key;
            r.key_hash = key_hash;
            r.value = value;
            if (bursts_on) begin
                if (send_quiet > 0) begin
                    send_quiet--;
                end else if ($urandom_range(0, 9) == 0) begin
                    send_quiet = $urandom_range(10, 40);
                end else if ($urandom_range(0, 2) == 0) begin
                    i_in_valid = 1'b0;
                    repeat ($urandom_range(1, 13)) @(negedge i_clk);
                end
            end
            i_in_valid = 1'b1;
            in_req = r;
            do @(posedge i_clk); while (o_in_stall);
            expected_rsp.push_back(map_predict(r));
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Hold the sender back until every predicted result has been seen.
    task automatic wait_results_drained;
        while (expected_rsp.size() != 0) @(negedge i_clk);
    endtask

    // Draw a fresh key pool; half the hashes share a few home slots to force collisions.
    task automatic roll_key_pool;
        int k;
        begin
            for (k = 0; k < POOL_KEYS; k++) begin
                pool_key[k] = $urandom;
                pool_hash[k] = $urandom;
                if (k % 2 == 0) begin
                    pool_hash[k][4:0] = 5'($urandom_range(0, 3));
                end
            end
        end
    endtask

    // Empty table, field extremes and a plain update.
    task automatic test_basic_extremes;
        begin
            send_req(MODE_GET, 32'h0, 32'h0, 32'h0);
            send_req(MODE_DEL, 32'h0, 32'h0, 32'h0);
            send_req(MODE_SET, 32'h0, 32'h0, 32'h0);
            send_req(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_req(MODE_GET, 32'h0, 32'h0, 32'hFFFF_FFFF);
            send_req(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
            send_req(MODE_SET, 32'h0, 32'h0, 32'hA5A5_5A5A);
            send_req(MODE_GET, 32'h0, 32'h0, 32'h0);
        end
    endtask

    // Keys sharing one probe chain: lookups past deleted slots and reuse of the first one.
    task automatic test_collision_reuse;
        logic [31:0] h;
        begin
            h = 32'h1234_5663;
            send_req(MODE_SET, 32'h11, h, 32'h1111);
            send_req(MODE_SET, 32'h22, h, 32'h2222);
            send_req(MODE_SET, 32'h33, h, 32'h3333);
            send_req(MODE_DEL, 32'h22, h, 32'h0);
            send_req(MODE_GET, 32'h22, h, 32'h0);
            send_req(MODE_GET, 32'h33, h, 32'h0);
            send_req(MODE_SET, 32'h44, h, 32'h4444);
            send_req(MODE_DEL, 32'h44, h, 32'h0);
            send_req(MODE_DEL, 32'h11, h, 32'h0);
            send_req(MODE_SET, 32'h55, h, 32'h5555);
            send_req(MODE_DEL, 32'h66, h, 32'h0);
        end
    endtask

    // The odd mode code behaves as a lookup and changes nothing.
    task automatic test_odd_mode;
        begin
            send_req(MODE_ODD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
            send_req(MODE_ODD, 32'h77, 32'h0000_0003, 32'h7777);
            send_req(MODE_GET, 32'h77, 32'h0000_0003, 32'h0);
        end
    endtask

    // Mostly pool traffic with random items; a few are noise or carry a wrong hash.
    task automatic test_random_mix(input int items, input int set_w, input int del_w);
        int j;
        int pick;
        int k;
        int m;
        logic [MODE_W-1:0] mode;
        begin
            for (j = 0; j < items; j++) begin
                pick = $urandom_range(0, 99);
                k = $urandom_range(0, POOL_KEYS - 1);
                if (pick < 12) begin
                    send_req(MODE_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                end else if (pick < 16) begin
                    send_req(MODE_W'($urandom_range(0, 3)), pool_key[k], $urandom, $urandom);
                end else begin
                    m = $urandom_range(0, 99);
                    if (m < set_w) begin
                        mode = MODE_SET;
                    end else if (m < set_w + del_w) begin
                        mode = MODE_DEL;
                    end else if (m < set_w + del_w + 5) begin
                        mode = MODE_ODD;
                    end else begin
                        mode = MODE_GET;
                    end
                    send_req(mode, pool_key[k], pool_hash[k], $urandom);
                end
            end
        end
    endtask

    // The sender stops until the block has returned every result, then sends a short mix.
    task automatic test_pause_for_results;
        begin
            wait_results_drained();
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
            test_random_mix(10, 40, 30);
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_no_idle_tail;
        begin
            bursts_on = 1'b0;
            test_random_mix(80, 40, 25);
        end
    endtask

    // Receiver stall: random stall bursts between runs of readiness.
    always @(negedge i_clk) begin
        if (stall_left == 0 && run_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(1, 13);
            end else if ($urandom_range(0, 4) == 0) begin
                run_left = $urandom_range(30, 80);
            end else begin
                run_left = $urandom_range(1, 20);
            end
        end
        if (!bursts_on) begin
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
            // A ready run always follows a stall burst, so bursts never merge.
            if (stall_left == 0) begin
                run_left = $urandom_range(1, 20);
            end
        end else begin
            run_left--;
            i_out_stall = 1'b0;
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_rsp);
                fail_count++;
            end else begin
                head_rsp = expected_rsp.pop_front();
                if (out_rsp.status !== head_rsp.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, head_rsp.status, out_rsp.status);
                    fail_count++;
                end
                if (out_rsp.value_out !== head_rsp.value_out) begin
                    $display("%0t: value_out mismatch, expected %h, actual %h",
                             $time, head_rsp.value_out, out_rsp.value_out);
                    fail_count++;
                end
                if (out_rsp.slot_index !== head_rsp.slot_index) begin
                    $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                             $time, head_rsp.slot_index, out_rsp.slot_index);
                    fail_count++;
                end
                if (out_rsp.live_count !== head_rsp.live_count) begin
                    $display("%0t: live_count mismatch, expected %0d, actual %0d",
                             $time, head_rsp.live_count, out_rsp.live_count);
                    fail_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            tbl_mark[s] = MARK_FREE;
            tbl_key[s] = '0;
            tbl_item[s] = '0;
        end
        tbl_live = 0;
        tbl_used = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_extremes();
        test_collision_reuse();
        test_odd_mode();
        roll_key_pool();
        test_random_mix(150, 70, 10);
        test_pause_for_results();
        test_random_mix(140, 35, 35);
        roll_key_pool();
        test_random_mix(140, 45, 25);
        test_no_idle_tail();

        // Let the last results arrive, then allow for any late extra transfer.
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== open_addressing_hash_map_unit.f =====
hdl/ohm_pkg.sv
hdl/ohm_ram.sv
hdl/open_addressing_hash_map_unit.sv
bench/open_addressing_hash_map_unit_tb.sv
